// ===== rtl/core/ccnr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccnr_pkg: shared types and constants of the chord/Newton root finder
// Fixed-point format, payload structs, status codes and register indexes.
// ----------------------------------------------------------------------------
package ccnr_pkg;

    localparam int FracBits = 24;
    localparam int WordBits = 32;
    localparam int TolBits  = 31;
    localparam int LimBits  = 8;
    localparam int PassBits = 9;
    localparam int CfgBits  = 31;
    localparam int ProdBits = 2 * WordBits;

    localparam logic [WordBits-1:0] QPointTwo =
        WordBits'(((64'd2 << FracBits) + 64'd5) / 64'd10);

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_SAME_SIGN = 2'd2,
        ST_ZERO_DIV  = 2'd3
    } t_status;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    typedef struct packed {
        logic signed [WordBits-1:0] left_end;
        logic signed [WordBits-1:0] right_end;
    } t_req;

    typedef struct packed {
        logic signed [WordBits-1:0] root_estimate;
        logic [PassBits-1:0]        passes;
        logic [1:0]                 status;
    } t_rsp;

endpackage

// ===== rtl/core/combined_chord_newton_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_chord_newton_root: interval root finder for f(x)=2x^2-x^3+0.2
// Sequenced datapath with one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// A request carries an interval [a,b] in signed Q8.24. The block evaluates
// f at both ends, reports a sign error if both are nonzero with equal sign,
// and otherwise refines the interval with Newton steps at one end and chord
// steps at the other until |b-a| drops below tolerance, the pass limit is
// hit or a divisor is zero. It returns floor((a+b)/2), the pass count and a
// status. After a request is accepted, f is evaluated at both ends and the
// signs checked. Each pass runs two 64-bit restoring divisions (one quotient
// bit per cycle) through the shared divider and six products through the
// shared multiplier; a final test ends the request. Ready is low while a
// request is in flight; the result register is freed as soon as the
// response is taken.
// ----------------------------------------------------------------------------
module combined_chord_newton_root (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  ccnr_pkg::t_req                    i_req,
    output logic                              o_valid,
    input  logic                              i_ready,
    output ccnr_pkg::t_rsp                    o_rsp,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [ccnr_pkg::CfgBits-1:0]      i_cfg_data
);

    localparam int W  = ccnr_pkg::WordBits;
    localparam int F  = ccnr_pkg::FracBits;
    localparam int PW = ccnr_pkg::ProdBits;
    localparam int DW = PW + 2;          // divider numerator width (signed)
    localparam int CW = 7;               // divide step counter

    typedef logic signed [W-1:0]  t_w;
    typedef logic signed [PW+1:0] t_x;   // wide signed intermediate

    typedef enum logic [4:0] {
        S_IDLE, S_FA0, S_FA1, S_FB0, S_FB1, S_CHECK, S_TEST,
        S_SL, S_NDIV, S_NDIV_RUN, S_CDIV, S_CDIV_RUN, S_UPD,
        S_FA0B, S_FA1B, S_FB0B, S_FB1B
    } t_state;

    t_state r_state;

    logic [ccnr_pkg::TolBits-1:0] r_tol;
    logic [ccnr_pkg::LimBits-1:0] r_lim;

    t_w r_a, r_b, r_fa, r_fb, r_sq, r_d, r_qn, r_qc;
    logic signed [W:0] r_den;            // f difference, exact
    logic r_newton_a;
    logic [ccnr_pkg::PassBits-1:0] r_pass;

    // serial divider
    logic [PW-1:0] r_dv_num;   // magnitude of numerator, shifted out
    logic [W-1:0]  r_dv_den;   // magnitude of divisor
    logic [W:0]    r_dv_rem;
    logic [PW-1:0] r_dv_q;
    logic          r_dv_neg;
    logic [CW-1:0] r_dv_cnt;

    logic  r_o_valid;
    ccnr_pkg::t_rsp r_rsp;

    // ---------------- helpers ----------------
    function automatic t_w sat_x(input t_x v);
        t_x mx, mn;
        begin
            mx = t_x'(signed'({1'b0, {(W-1){1'b1}}}));
            mn = -mx - t_x'(1);
            if (v > mx) sat_x = t_w'(mx);
            else if (v < mn) sat_x = t_w'(mn);
            else sat_x = t_w'(v);
        end
    endfunction

    // chord span, needed by the multiplier operand select
    t_w chord_span;
    assign chord_span = r_newton_a ? sat_x(t_x'(r_a) - t_x'(r_b))
                                   : sat_x(t_x'(r_b) - t_x'(r_a));

    // shared multiplier: one exact product a cycle, plus its rounded form
    // floor((x*y + half) >> F), saturated
    t_w mul_x, mul_y, mul_p;
    t_x mul_raw;
    assign mul_raw = t_x'(mul_x) * t_x'(mul_y);
    assign mul_p   = sat_x((mul_raw + (t_x'(1) <<< (F - 1))) >>> F);

    always_comb begin
        mul_x = r_a;
        mul_y = r_a;
        unique case (r_state)
            S_FA0, S_FA0B: begin mul_x = r_a;  mul_y = r_a; end
            S_FA1, S_FA1B: begin mul_x = r_sq; mul_y = r_a; end
            S_FB0, S_FB0B: begin mul_x = r_b;  mul_y = r_b; end
            S_FB1, S_FB1B: begin mul_x = r_sq; mul_y = r_b; end
            S_SL: begin
                mul_x = r_newton_a ? r_a : r_b;
                mul_y = r_newton_a ? r_a : r_b;
            end
            // chord numerator: fz * sat(u - z), exact
            S_CDIV: begin
                mul_x = r_newton_a ? r_fb : r_fa;
                mul_y = chord_span;
            end
            default: begin mul_x = r_a; mul_y = r_a; end
        endcase
    end

    // f from x2 (r_sq) and x3 (mul_p)
    t_w f_val;
    assign f_val = sat_x((t_x'(r_sq) <<< 1) - t_x'(mul_p) + t_x'(ccnr_pkg::QPointTwo));

    // sign helpers
    function automatic logic signed [1:0] sgn(input t_w v);
        sgn = (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
    endfunction

    t_w curv_a;
    assign curv_a = sat_x((t_x'(4) <<< F) - t_x'(6) * t_x'(r_a));

    logic [W:0] width_abs;
    t_x         wdiff;
    assign wdiff = t_x'(r_b) - t_x'(r_a);
    assign width_abs = wdiff[PW+1] ? (W+1)'(-wdiff) : (W+1)'(wdiff);

    // slope from mul_p = x*x
    t_w slope_v;
    assign slope_v = sat_x((t_x'(r_newton_a ? r_a : r_b) <<< 2) - t_x'(3) * t_x'(mul_p));

    t_x den_x;
    assign den_x = r_newton_a ? (t_x'(r_fa) - t_x'(r_fb)) : (t_x'(r_fb) - t_x'(r_fa));

    t_x newton_num;
    assign newton_num = t_x'(r_newton_a ? r_fa : r_fb) <<< F;

    // divider step
    logic [W:0] dv_trial;
    logic [W+1:0] dv_sh;
    assign dv_sh    = {r_dv_rem, r_dv_num[PW-1]};
    assign dv_trial = (W+1)'(dv_sh - {2'b00, r_dv_den});

    t_x dv_q_signed;
    assign dv_q_signed = r_dv_neg ? -t_x'({2'b00, r_dv_q}) : t_x'({2'b00, r_dv_q});

    t_x mid_sum;
    assign mid_sum = t_x'(r_a) + t_x'(r_b);

    assign o_ready = (r_state == S_IDLE) && !r_o_valid;
    assign o_valid = r_o_valid;
    assign o_rsp   = r_rsp;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= ccnr_pkg::TolBits'(83886);
            r_lim <= ccnr_pkg::LimBits'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccnr_pkg::REG_TOLERANCE: r_tol <= i_cfg_data[ccnr_pkg::TolBits-1:0];
                ccnr_pkg::REG_LIMIT:     r_lim <= i_cfg_data[ccnr_pkg::LimBits-1:0];
                default: ;
            endcase
        end
    end

    // load a signed numerator/divisor into the divider
    task automatic dv_load(input t_x num, input t_x den);
        begin
            r_dv_neg <= num[PW+1] ^ den[PW+1];
            r_dv_num <= PW'(num[PW+1] ? -num : num);
            r_dv_den <= W'(den[PW+1] ? -den : den);
            r_dv_rem <= '0;
            r_dv_q   <= '0;
            r_dv_cnt <= CW'(PW);
        end
    endtask

    task automatic finish(input t_w est, input logic [ccnr_pkg::PassBits-1:0] p,
                          input ccnr_pkg::t_status st);
        begin
            r_rsp.root_estimate <= est;
            r_rsp.passes        <= p;
            r_rsp.status        <= st;
            r_o_valid           <= 1'b1;
            r_state             <= S_IDLE;
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_a     <= i_req.left_end;
                        r_b     <= i_req.right_end;
                        r_state <= S_FA0;
                    end
                end
                S_FA0, S_FA0B: begin
                    r_sq    <= mul_p;
                    r_state <= (r_state == S_FA0) ? S_FA1 : S_FA1B;
                end
                S_FA1, S_FA1B: begin
                    r_fa    <= f_val;
                    r_state <= (r_state == S_FA1) ? S_FB0 : S_FB0B;
                end
                S_FB0, S_FB0B: begin
                    r_sq    <= mul_p;
                    r_state <= (r_state == S_FB0) ? S_FB1 : S_FB1B;
                end
                S_FB1: begin
                    r_fb    <= f_val;
                    r_state <= S_CHECK;
                end
                S_FB1B: begin
                    r_fb    <= f_val;
                    r_pass  <= r_pass + 1'b1;
                    r_state <= S_TEST;
                end
                S_CHECK: begin
                    // hold: exact sign products
                    if (sgn(r_fa) * sgn(r_fb) > 0) begin
                        finish('0, '0, ccnr_pkg::ST_SAME_SIGN);
                    end else begin
                        r_newton_a <= (sgn(r_fa) * sgn(curv_a)) > 0;
                        r_pass     <= ccnr_pkg::PassBits'(1);
                        r_state    <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_pass > {1'b0, r_lim}) begin
                        finish(t_w'(mid_sum >>> 1), r_pass, ccnr_pkg::ST_LIMIT);
                    end else if (width_abs < (W+1)'(r_tol)) begin
                        finish(t_w'(mid_sum >>> 1), r_pass, ccnr_pkg::ST_CONVERGED);
                    end else begin
                        r_state <= S_SL;
                    end
                end
                S_SL: begin
                    r_d     <= slope_v;
                    r_den   <= (W+1)'(den_x);
                    if (slope_v == '0 || den_x == '0) begin
                        finish(t_w'(mid_sum >>> 1), r_pass, ccnr_pkg::ST_ZERO_DIV);
                    end else begin
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    dv_load(newton_num, t_x'(r_d));
                    r_state <= S_NDIV_RUN;
                end
                S_NDIV_RUN, S_CDIV_RUN: begin
                    if (r_dv_cnt != '0) begin
                        if (!dv_sh[W+1] && dv_sh >= {2'b00, r_dv_den}) begin
                            r_dv_rem <= dv_trial;
                            r_dv_q   <= {r_dv_q[PW-2:0], 1'b1};
                        end else begin
                            r_dv_rem <= dv_sh[W:0];
                            r_dv_q   <= {r_dv_q[PW-2:0], 1'b0};
                        end
                        r_dv_num <= {r_dv_num[PW-2:0], 1'b0};
                        r_dv_cnt <= r_dv_cnt - 1'b1;
                    end else if (r_state == S_NDIV_RUN) begin
                        r_qn    <= sat_x(dv_q_signed);
                        r_state <= S_CDIV;
                    end else begin
                        r_qc    <= sat_x(dv_q_signed);
                        r_state <= S_UPD;
                    end
                end
                S_CDIV: begin
                    dv_load(mul_raw, t_x'(r_den));
                    r_state <= S_CDIV_RUN;
                end
                S_UPD: begin
                    if (r_newton_a) begin
                        r_a <= sat_x(t_x'(r_a) - t_x'(r_qn));
                        r_b <= sat_x(t_x'(r_b) - t_x'(r_qc));
                    end else begin
                        r_a <= sat_x(t_x'(r_a) - t_x'(r_qc));
                        r_b <= sat_x(t_x'(r_b) - t_x'(r_qn));
                    end
                    r_state <= S_FA0B;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the chord/Newton interval root finder
// Sends directed and random intervals under several tolerance and pass-limit
// settings, with random sender and receiver stalls. Each response is checked
// against a fixed-point predictor of the combined method.
// ----------------------------------------------------------------------------
module tb;

    localparam longint QOne  = 64'sd1 <<< ccnr_pkg::FracBits;
    localparam longint QHalf = 64'sd1 <<< (ccnr_pkg::FracBits - 1);
    localparam longint WMax  = (64'sd1 <<< (ccnr_pkg::WordBits - 1)) - 1;
    localparam longint WMin  = -WMax - 1;

    // Root predictor: tracks register copies and holds the expected responses.
    class root_scoreboard;
        longint tol = 83886;
        int     lim = 100;
        ccnr_pkg::t_rsp expected_q[$];
        int     errors = 0;
        int     checked = 0;
        int     status_seen[4] = '{0, 0, 0, 0};

        function longint sat(longint v);
            if (v > WMax) return WMax;
            if (v < WMin) return WMin;
            return v;
        endfunction

        function longint qmul(longint x, longint y);
            return sat((x * y + QHalf) >>> ccnr_pkg::FracBits);
        endfunction

        function longint cubic(longint x);
            longint x2, x3;
            x2 = qmul(x, x);
            x3 = qmul(x2, x);
            return sat(2 * x2 - x3 + longint'(ccnr_pkg::QPointTwo));
        endfunction

        function longint slope(longint x);
            return sat(4 * x - 3 * qmul(x, x));
        endfunction

        function int sgn(longint v);
            return (v > 0) - (v < 0);
        endfunction

        function ccnr_pkg::t_rsp solve_interval(ccnr_pkg::t_req r);
            ccnr_pkg::t_rsp    o;
            longint            a, b, fa, fb, na, nb, d, den, width;
            int                pass;
            bit                newton_a;
            ccnr_pkg::t_status st;
            a = r.left_end;
            b = r.right_end;
            fa = cubic(a);
            fb = cubic(b);
            st = ccnr_pkg::ST_LIMIT;
            if (sgn(fa) * sgn(fb) > 0) begin
                o.root_estimate = '0;
                o.passes = '0;
                o.status = ccnr_pkg::ST_SAME_SIGN;
                return o;
            end
            // positive f*f'' at a puts the Newton steps on the left end
            newton_a = sgn(fa) * sgn(sat(4 * QOne - 6 * a)) > 0;
            for (pass = 1; pass <= lim; pass++) begin
                width = b - a;
                if (width < 0) width = -width;
                if (width < tol) begin
                    st = ccnr_pkg::ST_CONVERGED;
                    break;
                end
                if (newton_a) begin
                    d = slope(a);
                    den = fa - fb;
                    if (d == 0 || den == 0) begin
                        st = ccnr_pkg::ST_ZERO_DIV;
                        break;
                    end
                    na = sat(a - sat((fa * QOne) / d));
                    nb = sat(b - sat((fb * sat(a - b)) / den));
                end else begin
                    d = slope(b);
                    den = fb - fa;
                    if (d == 0 || den == 0) begin
                        st = ccnr_pkg::ST_ZERO_DIV;
                        break;
                    end
                    na = sat(a - sat((fa * sat(b - a)) / den));
                    nb = sat(b - sat((fb * QOne) / d));
                end
                a = na;
                b = nb;
                fa = cubic(a);
                fb = cubic(b);
            end
            o.root_estimate = ccnr_pkg::WordBits'((a + b) >>> 1);
            o.passes = ccnr_pkg::PassBits'(pass);
            o.status = st;
            return o;
        endfunction

        function void note_request(ccnr_pkg::t_req r);
            expected_q.push_back(solve_interval(r));
        endfunction

        function void check_response(ccnr_pkg::t_rsp got);
            ccnr_pkg::t_rsp exp_rsp;
            checked++;
            if (expected_q.size() == 0) begin
                $error("response with nothing pending: %h", got);
                errors++;
                return;
            end
            exp_rsp = expected_q.pop_front();
            status_seen[exp_rsp.status]++;
            if (got.root_estimate !== exp_rsp.root_estimate) begin
                $error("root_estimate: expected %0d, got %0d",
                       exp_rsp.root_estimate, got.root_estimate);
                errors++;
            end
            if (got.passes !== exp_rsp.passes) begin
                $error("passes: expected %0d, got %0d", exp_rsp.passes, got.passes);
                errors++;
            end
            if (got.status !== exp_rsp.status) begin
                $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    ccnr_pkg::t_req                i_req = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    ccnr_pkg::t_rsp                o_rsp;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_idx = ccnr_pkg::REG_TOLERANCE;
    logic [ccnr_pkg::CfgBits-1:0]  i_cfg_data = '0;

    root_scoreboard sb = new();
    int tx_idle_pct = 29;
    int rx_idle_pct = 81;
    int rx_hold = 0;
    int sent = 0;

    combined_chord_newton_root uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Response side: check every accepted response, then pick next ready.
    // A pending hold-off forces ready low and counts down one per cycle.
    always @(posedge i_clk) begin
        if (o_valid && i_ready) sb.check_response(o_rsp);
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one request; optionally drop valid for a random gap first.
    task automatic send_request(input ccnr_pkg::t_req r);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        sent++;
    endtask

    task automatic send_pair(input longint a, input longint b);
        ccnr_pkg::t_req r;
        r.left_end = a[ccnr_pkg::WordBits-1:0];
        r.right_end = b[ccnr_pkg::WordBits-1:0];
        send_request(r);
    endtask

    // Drop valid and hold until every pending response has come back.
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle and mirror them.
    task automatic set_registers(input longint tol, input int lim);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= ccnr_pkg::REG_TOLERANCE;
        i_cfg_data <= ccnr_pkg::CfgBits'(tol);
        @(posedge i_clk);
        i_cfg_idx <= ccnr_pkg::REG_LIMIT;
        i_cfg_data <= ccnr_pkg::CfgBits'(lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.tol = tol;
        sb.lim = lim;
    endtask

    // Mostly intervals that bracket the root near 2.05, sometimes swapped,
    // the rest raw 32-bit noise.
    task automatic send_random;
        longint a, b;
        ccnr_pkg::t_req r;
        if ($urandom_range(99) < 80) begin
            a = $urandom_range(0, 3 * QOne) - QOne;
            b = $urandom_range(0, 4 * QOne) + (QOne * 21) / 10;
            if ($urandom_range(1)) send_pair(b, a);
            else send_pair(a, b);
        end else begin
            r.left_end = $urandom;
            r.right_end = $urandom;
            send_request(r);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, field extremes, same signs, zero slope.
        send_pair(WMin, WMin);
        send_pair(WMax, WMax);
        send_pair(WMin, WMax);
        send_pair(WMax, WMin);
        send_pair(0, 0);
        send_pair(0, 3 * QOne);          // zero slope at the Newton end
        send_pair(3 * QOne, 0);
        send_pair(4 * QOne / 3, 3 * QOne);
        send_pair(QOne, 5 * QOne / 2);
        send_pair(2 * QOne, 21 * QOne / 10);
        send_pair(-QOne, 10 * QOne);
        send_pair(2 * QOne, 2 * QOne);
        send_pair(-1, 1);

        // Widest tolerance: a bracketing interval converges on the first pass.
        set_registers(WMax, 255);
        send_pair(QOne, 3 * QOne);
        send_pair(WMin, WMax);
        // Tightest tolerance with the largest limit: runs out of passes.
        set_registers(1, 255);
        send_pair(QOne, 3 * QOne);
        send_pair(3 * QOne, 0);
        set_registers(83886, 1);
        send_pair(0, 4 * QOne);
        send_pair(QOne, 3 * QOne);

        // Random phases under three stall profiles.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                tx_idle_pct = 81;
                rx_idle_pct = 29;
            end else if (ph == 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int k = 0; k < 43; k++) begin
                if (k % 10 == 0)
                    set_registers($urandom_range(1, 1 << 22), $urandom_range(1, 24));
                send_random();
            end
        end

        // Long receiver hold-off while requests keep coming: block backs up.
        drain();
        rx_hold = 20000;
        for (int k = 0; k < 4; k++) send_random();
        drain();
        send_pair(0, 3 * QOne);

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d intervals, checked %0d responses", sent, sb.checked);
        $display("status mix: converged %0d, limit %0d, same sign %0d, zero divisor %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ccnr_pkg.sv
rtl/core/combined_chord_newton_root.sv
bench/tb.sv
